>>> rtl/core/rhc_pkg.sv
// Shared types and constants for the pixel color space converter.
package rhc_pkg;

  // Conversion mode register codes.
  localparam logic [1:0] MODE_RGB_HSV  = 2'd0;
  localparam logic [1:0] MODE_HSV_RGB  = 2'd1;
  localparam logic [1:0] MODE_RGB_CMYK = 2'd2;
  localparam logic [1:0] MODE_CMYK_RGB = 2'd3;

  // Reciprocal constants for the rounded divisions by 510 and 30600.
  localparam logic [8:0]  P_RECIP = 9'd257;
  localparam int          P_SHIFT = 17;
  localparam logic [9:0]  Q_RECIP = 10'd548;
  localparam int          Q_SHIFT = 24;

  // One converted pixel.
  typedef struct packed {
    logic signed [9:0] a;
    logic [7:0]        b;
    logic [7:0]        c;
    logic [7:0]        d;
  } pix_out_t;

  // Per-pixel control that travels beside the arithmetic stages.
  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] hue_off;
    logic       achrom;
    logic       grey;
    logic [7:0] val;
    logic [2:0] sext;
    pix_out_t   direct;
  } side_t;

endpackage

>>> rtl/core/rgb_hsv_cmyk_pixel_converter_core.sv
// Top level of the pipelined RGB, HSV and CMYK pixel converter.
//
// Pixels enter on the s_axis stream and leave on the m_axis stream, one
// result transaction for every input transaction, in order. The cfg channel
// writes the two-bit conversion mode: 0 RGB to HSV, 1 HSV to RGB, 2 RGB to
// CMYK, 3 CMYK to RGB. It is always ready and should only be written while
// no pixel is in flight.
// The datapath is a seven-stage pipeline that takes one pixel every cycle
// while the receiver does not stall it. The length is set by the
// two-bits-per-stage dividers for saturation and hue and by the multiply
// and reciprocal chain of the HSV to RGB path.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
// Reset clears the pipeline valid bits and sets the mode to RGB to HSV.
module rgb_hsv_cmyk_pixel_converter_core import rhc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // chan_a[10:0], chan_b, chan_c, chan_d, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // out_a[9:0], out_b, out_c, out_d, zero pad
);

  localparam logic [1:0] WHICH_R = 2'd0;
  localparam logic [1:0] WHICH_G = 2'd1;
  localparam logic [1:0] WHICH_B = 2'd2;

  logic [1:0] mode;
  logic       en;
  logic [6:0] vld;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RGB_HSV;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  // The pipeline moves whenever the output register is free or being taken.
  assign en            = !vld[6] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], s_axis_tvalid};
    end
  end

  // Stage 0: input register.
  logic signed [10:0] a0;
  logic [7:0]         b0, c0, d0;
  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= s_axis_tdata[10:0];
      b0 <= s_axis_tdata[18:11];
      c0 <= s_axis_tdata[26:19];
      d0 <= s_axis_tdata[34:27];
    end
  end

  // Clamp, extremes, divider operands and the direct CMYK results.
  logic [7:0]  ac, mx, mn, dd, hx, cc, mm, yy, kk;
  logic [1:0]  which;
  logic [8:0]  hue_off;
  logic [16:0] s_num;
  logic [14:0] h_num;
  logic signed [11:0] h_ext, hm_s;
  logic [8:0]  hm;
  logic [2:0]  sext;
  logic [5:0]  hf;
  logic [8:0]  ksum_a, ksum_b, ksum_c;
  pix_out_t    direct;
  side_t       side_a;

  always_comb begin
    if (a0[10]) begin
      ac = 8'd0;
    end else if (a0[9:8] != 2'd0) begin
      ac = 8'd255;
    end else begin
      ac = a0[7:0];
    end

    mx = ac;
    which = WHICH_R;
    if (b0 > mx) begin
      mx = b0;
      which = WHICH_G;
    end
    if (c0 > mx) begin
      mx = c0;
      which = WHICH_B;
    end
    mn = ac;
    if (b0 < mn) mn = b0;
    if (c0 < mn) mn = c0;
    dd = mx - mn;

    // Hue numerator; the wrapped eight-bit sums stay within 0..d.
    case (which)
      WHICH_R: begin
        if (b0 >= c0) begin
          hx = b0 - c0;
          hue_off = 9'd0;
        end else begin
          hx = b0 - c0 + dd;
          hue_off = 9'd300;
        end
      end
      WHICH_G: begin
        if (c0 > ac) begin
          hx = c0 - ac;
          hue_off = 9'd120;
        end else begin
          hx = c0 - ac + dd;
          hue_off = 9'd60;
        end
      end
      default: begin
        if (ac > b0) begin
          hx = ac - b0;
          hue_off = 9'd240;
        end else begin
          hx = ac - b0 + dd;
          hue_off = 9'd180;
        end
      end
    endcase
    s_num = (17'(dd) << 9) - (17'(dd) << 1) + 17'(mx);
    h_num = (15'(hx) << 7) - (15'(hx) << 3) + 15'(dd);

    // Hue reduced into 0..359, then split into sextant and remainder.
    h_ext = {a0[10], a0};
    if (h_ext < 0) begin
      if (h_ext + 12'sd360 >= 0) begin
        hm_s = h_ext + 12'sd360;
      end else if (h_ext + 12'sd720 >= 0) begin
        hm_s = h_ext + 12'sd720;
      end else begin
        hm_s = h_ext + 12'sd1080;
      end
    end else if (h_ext >= 12'sd720) begin
      hm_s = h_ext - 12'sd720;
    end else if (h_ext >= 12'sd360) begin
      hm_s = h_ext - 12'sd360;
    end else begin
      hm_s = h_ext;
    end
    hm = hm_s[8:0];
    if (hm >= 9'd300) begin
      sext = 3'd5;
      hf = 6'(hm - 9'd300);
    end else if (hm >= 9'd240) begin
      sext = 3'd4;
      hf = 6'(hm - 9'd240);
    end else if (hm >= 9'd180) begin
      sext = 3'd3;
      hf = 6'(hm - 9'd180);
    end else if (hm >= 9'd120) begin
      sext = 3'd2;
      hf = 6'(hm - 9'd120);
    end else if (hm >= 9'd60) begin
      sext = 3'd1;
      hf = 6'(hm - 9'd60);
    end else begin
      sext = 3'd0;
      hf = 6'(hm);
    end

    // CMYK in both directions fits in this stage.
    cc = ~ac;
    mm = ~b0;
    yy = ~c0;
    kk = (cc < mm) ? cc : mm;
    if (yy < kk) kk = yy;
    ksum_a = 9'(ac) + 9'(d0);
    ksum_b = 9'(b0) + 9'(d0);
    ksum_c = 9'(c0) + 9'(d0);
    direct = '0;
    unique case (mode)
      MODE_RGB_CMYK: begin
        direct.a = {2'b00, cc - kk};
        direct.b = mm - kk;
        direct.c = yy - kk;
        direct.d = kk;
      end
      MODE_CMYK_RGB: begin
        direct.a = {2'b00, ksum_a[8] ? 8'd0 : ~ksum_a[7:0]};
        direct.b = ksum_b[8] ? 8'd0 : ~ksum_b[7:0];
        direct.c = ksum_c[8] ? 8'd0 : ~ksum_c[7:0];
      end
      MODE_RGB_HSV, MODE_HSV_RGB: begin
      end
    endcase

    side_a.mode    = mode;
    side_a.hue_off = hue_off;
    side_a.achrom  = (dd == 8'd0);
    side_a.grey    = (b0 == 8'd0) || (a0 == -11'sd1);
    side_a.val     = (mode == MODE_HSV_RGB) ? c0 : mx;
    side_a.sext    = sext;
    side_a.direct  = direct;
  end

  // Stage 1: divider operands, HSV operands and sideband.
  side_t       side_q [1:5];
  logic [16:0] s_num1;
  logic [8:0]  s_den1;
  logic [14:0] h_num1;
  logic [8:0]  h_den1;
  logic [7:0]  hs1;
  logic [5:0]  hf1;
  always_ff @(posedge clk) begin
    if (en) begin
      s_num1 <= s_num;
      s_den1 <= {mx, 1'b0};
      h_num1 <= h_num;
      h_den1 <= {dd, 1'b0};
      hs1    <= b0;
      hf1    <= hf;
      side_q[1] <= side_a;
      for (int k = 2; k <= 5; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stages 2 to 5: saturation and hue dividers.
  logic [7:0] s_quo, h_quo;
  rhc_div #(.NW(17), .DW(9), .QW(8)) u_sat_div (
    .clk(clk), .en(en), .num(s_num1), .den(s_den1), .quo(s_quo)
  );
  rhc_div #(.NW(15), .DW(9), .QW(8)) u_hue_div (
    .clk(clk), .en(en), .num(h_num1), .den(h_den1), .quo(h_quo)
  );

  // HSV to RGB products and rounded divisions, registered in stages 2 to 5.
  logic [15:0] x2;
  logic [13:0] sf2, st2;
  logic [16:0] y3, y4;
  logic [21:0] wq3, wt3;
  logic [24:0] py4;
  logic [22:0] zq4, zt4, zq5, zt5;
  logic [31:0] pq5, pt5;
  logic [7:0]  p5;
  logic [7:0]  p0;
  logic [16:0] p_rem;
  always_comb begin
    p0    = py4[P_SHIFT+7:P_SHIFT];
    p_rem = y4 - ((17'(p0) << 9) - (17'(p0) << 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2  <= 16'(side_q[1].val) * 16'(8'd255 - hs1);
      sf2 <= 14'(hs1) * 14'(hf1);
      st2 <= 14'(hs1) * 14'(6'd60 - hf1);
      y3  <= (17'(x2) << 1) + 17'd255;
      wq3 <= 22'(side_q[2].val) * 22'(14'd15300 - sf2);
      wt3 <= 22'(side_q[2].val) * 22'(14'd15300 - st2);
      y4  <= y3;
      py4 <= 25'(y3) * 25'(P_RECIP);
      zq4 <= (23'(wq3) << 1) + 23'd15300;
      zt4 <= (23'(wt3) << 1) + 23'd15300;
      p5  <= p0 + ((p_rem >= 17'd510) ? 8'd1 : 8'd0);
      zq5 <= zq4;
      zt5 <= zt4;
      pq5 <= 32'(zq4) * 32'(Q_RECIP);
      pt5 <= 32'(zt4) * 32'(Q_RECIP);
    end
  end

  // Final corrections, hue assembly and mode selection.
  logic [7:0]  q0, t0, qv, tv;
  logic [22:0] q_rem, t_rem;
  logic [8:0]  hue_sum, hue;
  pix_out_t    res;
  pix_out_t    out_q;
  side_t       sd;
  always_comb begin
    sd = side_q[5];
    q0 = pq5[Q_SHIFT+7:Q_SHIFT];
    t0 = pt5[Q_SHIFT+7:Q_SHIFT];
    q_rem = zq5 - 23'(q0) * 23'd30600;
    t_rem = zt5 - 23'(t0) * 23'd30600;
    qv = q0 + ((q_rem >= 23'd30600) ? 8'd1 : 8'd0);
    tv = t0 + ((t_rem >= 23'd30600) ? 8'd1 : 8'd0);
    hue_sum = sd.hue_off + 9'(h_quo);
    hue = (hue_sum >= 9'd360) ? hue_sum - 9'd360 : hue_sum;
    res = '0;
    unique case (sd.mode)
      MODE_RGB_HSV: begin
        res.a = sd.achrom ? -10'sd1 : $signed({1'b0, hue});
        res.b = sd.achrom ? 8'd0 : s_quo;
        res.c = sd.val;
      end
      MODE_HSV_RGB: begin
        if (sd.grey) begin
          res.a = {2'b00, sd.val};
          res.b = sd.val;
          res.c = sd.val;
        end else begin
          case (sd.sext)
            3'd0: begin res.a = {2'b00, sd.val}; res.b = tv;     res.c = p5;     end
            3'd1: begin res.a = {2'b00, qv};     res.b = sd.val; res.c = p5;     end
            3'd2: begin res.a = {2'b00, p5};     res.b = sd.val; res.c = tv;     end
            3'd3: begin res.a = {2'b00, p5};     res.b = qv;     res.c = sd.val; end
            3'd4: begin res.a = {2'b00, tv};     res.b = p5;     res.c = sd.val; end
            default: begin res.a = {2'b00, sd.val}; res.b = p5;  res.c = qv;     end
          endcase
        end
      end
      MODE_RGB_CMYK, MODE_CMYK_RGB: begin
        res = sd.direct;
      end
    endcase
  end

  // Stage 6: output register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_q.d, out_q.c, out_q.b, out_q.a};

endmodule

>>> rtl/core/rhc_div.sv
// Pipelined restoring divider that resolves two quotient bits per stage.
module rhc_div #(
  parameter int NW = 17,
  parameter int DW = 9,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;
  localparam int NS = QW / 2;

  logic [RW-1:0] rem_q   [NS-1];
  logic [DW-1:0] den_q   [NS-1];
  logic [QW-1:0] quo_q   [NS];
  logic [RW-1:0] rem_src [NS];
  logic [RW-1:0] rem_nxt [NS];
  logic [DW-1:0] den_src [NS];
  logic [QW-1:0] quo_src [NS];
  logic [QW-1:0] quo_nxt [NS];

  // Each stage tries the two next quotient bits, highest first.
  always_comb begin
    logic [RW-1:0] trial;
    logic [RW-1:0] mid;
    rem_src[0] = RW'(num);
    den_src[0] = den;
    quo_src[0] = '0;
    for (int s = 1; s < NS; s++) begin
      rem_src[s] = rem_q[s-1];
      den_src[s] = den_q[s-1];
      quo_src[s] = quo_q[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      quo_nxt[s] = quo_src[s];
      trial = RW'(den_src[s]) << (QW - 1 - 2 * s);
      if (rem_src[s] >= trial) begin
        mid = rem_src[s] - trial;
        quo_nxt[s][QW-1-2*s] = 1'b1;
      end else begin
        mid = rem_src[s];
      end
      trial = RW'(den_src[s]) << (QW - 2 - 2 * s);
      if (mid >= trial) begin
        rem_nxt[s] = mid - trial;
        quo_nxt[s][QW-2-2*s] = 1'b1;
      end else begin
        rem_nxt[s] = mid;
      end
    end
  end

  // Stage registers advance together with the rest of the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS - 1; s++) begin
        rem_q[s] <= rem_nxt[s];
        den_q[s] <= den_src[s];
      end
      for (int s = 0; s < NS; s++) begin
        quo_q[s] <= quo_nxt[s];
      end
    end
  end

  assign quo = quo_q[NS-1];

endmodule

>>> tb/sv/tb_rgb_hsv_cmyk_pixel_converter_core.sv
// Self-checking testbench for the RGB, HSV and CMYK pixel converter core.
`timescale 1ns / 100ps

module tb_rgb_hsv_cmyk_pixel_converter_core;
  import rhc_pkg::*;

  localparam int LATENCY     = 7;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [10:0] a;
    logic [7:0]         b;
    logic [7:0]         c;
    logic [7:0]         d;
  } pix_in_t;

  typedef struct {
    logic [1:0]        mode;
    pix_in_t           px;
    logic              known;
    logic signed [9:0] ea;
    logic [7:0]        eb;
    logic [7:0]        ec;
    logic [7:0]        ed;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // chan_a[10:0], chan_b, chan_c, chan_d, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_a[9:0], out_b, out_c, out_d, zero pad

  pix_out_t    expected_pixels[$];
  logic [1:0]  active_mode;
  int          error_count;
  int          cycle_count;
  logic        stim_done;
  logic        hold_off;
  logic        hold_req;
  logic        no_idle;

  rgb_hsv_cmyk_pixel_converter_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_byte(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Computes the converted pixel for one input under the given mode.
  function automatic pix_out_t convert_pixel(logic [1:0] mode, pix_in_t px);
    pix_out_t res;
    int a, b, c, d, mx, mn, dl, hue, sat, r, g, bl, f, sext, p, q, t, kk;
    int top;
    a = int'(px.a);
    b = int'(px.b);
    c = int'(px.c);
    d = int'(px.d);
    res = '0;
    case (mode)
      MODE_RGB_HSV: begin
        r = clamp_byte(a);
        mx = r; mn = r; top = 0;
        if (b > mx) begin mx = b; top = 1; end
        if (c > mx) begin mx = c; top = 2; end
        if (b < mn) mn = b;
        if (c < mn) mn = c;
        dl = mx - mn;
        sat = (mx != 0) ? (510 * dl + mx) / (2 * mx) : 0;
        // Achromatic pixels carry an undefined hue.
        if (sat == 0 || dl == 0) begin
          hue = -1;
          if (dl == 0) sat = 0;
        end else begin
          if (top == 0) begin
            if (b >= c) hue = (120 * (b - c) + dl) / (2 * dl);
            else hue = (120 * (b - c + dl) + dl) / (2 * dl) + 300;
          end else if (top == 1) begin
            if (c > r) hue = 120 + (120 * (c - r) + dl) / (2 * dl);
            else hue = 60 + (120 * (c - r + dl) + dl) / (2 * dl);
          end else begin
            if (r > b) hue = 240 + (120 * (r - b) + dl) / (2 * dl);
            else hue = 180 + (120 * (r - b + dl) + dl) / (2 * dl);
          end
          if (hue >= 360) hue -= 360;
        end
        res.a = hue[9:0]; res.b = sat[7:0]; res.c = mx[7:0];
      end
      MODE_HSV_RGB: begin
        r = c; g = c; bl = c;
        if (b != 0 && a != -1) begin
          hue = a % 360;
          if (hue < 0) hue += 360;
          f = hue % 60;
          sext = hue / 60;
          p = (2 * c * (255 - b) + 255) / 510;
          q = (2 * c * (15300 - b * f) + 15300) / 30600;
          t = (2 * c * (15300 - b * (60 - f)) + 15300) / 30600;
          case (sext)
            0: begin r = c; g = t; bl = p; end
            1: begin r = q; g = c; bl = p; end
            2: begin r = p; g = c; bl = t; end
            3: begin r = p; g = q; bl = c; end
            4: begin r = t; g = p; bl = c; end
            default: begin r = c; g = p; bl = q; end
          endcase
        end
        res.a = r[9:0]; res.b = g[7:0]; res.c = bl[7:0];
      end
      MODE_RGB_CMYK: begin
        r = 255 - clamp_byte(a); g = 255 - b; bl = 255 - c;
        kk = (r < g) ? r : g;
        if (bl < kk) kk = bl;
        res.a = 10'(r - kk); res.b = 8'(g - kk); res.c = 8'(bl - kk); res.d = kk[7:0];
      end
      default: begin
        r = clamp_byte(255 - (clamp_byte(a) + d));
        g = clamp_byte(255 - (b + d));
        bl = clamp_byte(255 - (c + d));
        res.a = r[9:0]; res.b = g[7:0]; res.c = bl[7:0];
      end
    endcase
    return res;
  endfunction

  // Offers one pixel and waits for its transaction; queues the expectation.
  task automatic send_pixel(pix_in_t px, logic known, pix_out_t fixed);
    pix_out_t model;
    model = convert_pixel(active_mode, px);
    if (known && model !== fixed) begin
      $error("table entry disagrees with predictor: expected %h got %h", fixed, model);
      error_count++;
    end
    while (!no_idle && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, px.d, px.c, px.b, px.a};
    expected_pixels.push_back(known ? fixed : model);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Waits for the pipeline to drain, then writes the mode register.
  task automatic write_mode(logic [1:0] mode);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_mode = mode;
  endtask

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    case ($urandom_range(9))
      0: px.a = 11'($signed($urandom_range(2047)));
      1: px.a = -11'sd1;
      default: px.a = 11'($urandom_range(active_mode == MODE_HSV_RGB ? 1023 : 255));
    endcase
    px.b = $urandom_range(9) == 0 ? 8'd0 : 8'($urandom);
    px.c = 8'($urandom);
    px.d = 8'($urandom);
    return px;
  endfunction

  // Directed table: mode, pixel, and a typed-in result where obvious.
  stim_row_t table_rows[] = '{
    '{MODE_RGB_HSV, '{11'sd0, 8'd0, 8'd0, 8'd0}, 1'b1, -10'sd1, 8'd0, 8'd0, 8'd0},
    '{MODE_RGB_HSV, '{11'sd255, 8'd255, 8'd255, 8'd0}, 1'b1, -10'sd1, 8'd0, 8'd255, 8'd0},
    '{MODE_RGB_HSV, '{11'sd255, 8'd0, 8'd0, 8'd0}, 1'b1, 10'sd0, 8'd255, 8'd255, 8'd0},
    '{MODE_RGB_HSV, '{11'sd1023, 8'd0, 8'd255, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_RGB_HSV, '{-11'sd1024, 8'd200, 8'd10, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_RGB_HSV, '{11'sd255, 8'd0, 8'd1, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_RGB_HSV, '{11'sd100, 8'd50, 8'd250, 8'd255}, 1'b0, 0, 0, 0, 0},
    '{MODE_HSV_RGB, '{-11'sd1, 8'd255, 8'd77, 8'd0}, 1'b1, 10'sd77, 8'd77, 8'd77, 8'd0},
    '{MODE_HSV_RGB, '{11'sd120, 8'd0, 8'd200, 8'd0}, 1'b1, 10'sd200, 8'd200, 8'd200, 8'd0},
    '{MODE_HSV_RGB, '{11'sd0, 8'd255, 8'd255, 8'd0}, 1'b1, 10'sd255, 8'd0, 8'd0, 8'd0},
    '{MODE_HSV_RGB, '{11'sd1023, 8'd255, 8'd255, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_HSV_RGB, '{-11'sd1024, 8'd128, 8'd255, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_HSV_RGB, '{-11'sd2, 8'd200, 8'd100, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_HSV_RGB, '{11'sd359, 8'd255, 8'd255, 8'd255}, 1'b0, 0, 0, 0, 0},
    '{MODE_HSV_RGB, '{11'sd200, 8'd90, 8'd180, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_RGB_CMYK, '{11'sd0, 8'd0, 8'd0, 8'd0}, 1'b1, 10'sd0, 8'd0, 8'd0, 8'd255},
    '{MODE_RGB_CMYK, '{11'sd255, 8'd255, 8'd255, 8'd0}, 1'b1, 10'sd0, 8'd0, 8'd0, 8'd0},
    '{MODE_RGB_CMYK, '{11'sd1023, 8'd0, 8'd128, 8'd255}, 1'b0, 0, 0, 0, 0},
    '{MODE_RGB_CMYK, '{-11'sd1024, 8'd64, 8'd255, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_CMYK_RGB, '{11'sd0, 8'd0, 8'd0, 8'd0}, 1'b1, 10'sd255, 8'd255, 8'd255, 8'd0},
    '{MODE_CMYK_RGB, '{11'sd255, 8'd255, 8'd255, 8'd255}, 1'b1, 10'sd0, 8'd0, 8'd0, 8'd0},
    '{MODE_CMYK_RGB, '{11'sd1023, 8'd10, 8'd20, 8'd0}, 1'b0, 0, 0, 0, 0},
    '{MODE_CMYK_RGB, '{-11'sd1, 8'd100, 8'd200, 8'd100}, 1'b0, 0, 0, 0, 0}
  };

  // Stimulus: reset, directed table, then random phases per mode.
  initial begin
    pix_out_t fixed;
    logic [1:0] mode;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = MODE_RGB_HSV;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    active_mode = MODE_RGB_HSV;
    stim_done = 1'b0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // The first row runs under the reset mode with no register write.
    foreach (table_rows[i]) begin
      if (i != 0 && table_rows[i].mode != active_mode) write_mode(table_rows[i].mode);
      fixed.a = table_rows[i].ea; fixed.b = table_rows[i].eb;
      fixed.c = table_rows[i].ec; fixed.d = table_rows[i].ed;
      send_pixel(table_rows[i].px, table_rows[i].known, fixed);
    end
    for (int ph = 0; ph < 8; ph++) begin
      mode = (ph < 4) ? 2'(ph) : 2'($urandom_range(3));
      write_mode(mode);
      no_idle = (ph == 2);
      for (int n = 0; n < 160; n++) begin
        // The long receiver hold-off starts while this phase keeps sending.
        if (ph == 1 && n == 40) hold_req = 1'b1;
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off, and a quiet stretch.
  initial begin
    int   hold_count;
    logic hold_done;
    hold_off = 1'b0;
    hold_count = 0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_off = 1'b1;
        hold_count++;
        if (hold_count == 100) begin
          hold_off = 1'b0;
          hold_done = 1'b1;
        end
      end
      m_axis_tready <= !hold_off && (no_idle || $urandom_range(99) >= 8);
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    pix_out_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.a = m_axis_tdata[9:0];
      got.b = m_axis_tdata[17:10];
      got.c = m_axis_tdata[25:18];
      got.d = m_axis_tdata[33:26];
      if (expected_pixels.size() == 0) begin
        $error("result transaction with no expectation: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.a !== want.a) begin
          $error("out_a expected %0d actual %0d", want.a, got.a); error_count++;
        end
        if (got.b !== want.b) begin
          $error("out_b expected %0d actual %0d", want.b, got.b); error_count++;
        end
        if (got.c !== want.c) begin
          $error("out_c expected %0d actual %0d", want.c, got.c); error_count++;
        end
        if (got.d !== want.d) begin
          $error("out_d expected %0d actual %0d", want.d, got.d); error_count++;
        end
        if (m_axis_tdata[39:34] !== '0) begin
          $error("pad bits expected 0 actual %h", m_axis_tdata[39:34]); error_count++;
        end
      end
    end
  end

  // End of run and cycle limit.
  initial begin
    error_count = 0;
    cycle_count = 0;
    fork
      begin
        wait (stim_done);
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (LATENCY * 3) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        error_count++;
      end
    join_any
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
    end else if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
